// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the max flow core.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MFEK_ASSERT(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("mfek check failed");

// A cause in one cycle must be followed by an effect in the next.
`define MFEK_ASSERT_NEXT(label, clk, rstn, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
        else $error("mfek check failed");

// A condition that must imply another in the same cycle.
`define MFEK_ASSERT_IMPL(label, clk, rstn, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |-> (effect)) \
        else $error("mfek check failed");

`endif

// ===== rtl/mfek_pkg.sv =====
// Shared types, constants and codes of the Edmonds-Karp max flow core.
// No dependencies; every module file of the core imports this package.
package mfek_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 16;

    localparam int MODE_W      = 2;
    localparam int FIELD_W     = 7;
    localparam int CAP_W       = 16;
    localparam int FLOW_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int RES_W       = 24;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FIELD_W-1:0]  VC_RESET = 7'd64;
    localparam logic [FLOW_W-1:0]   INT_MAX  = 32'h7FFF_FFFF;
    localparam logic [FLOW_W-1:0]   FLOW_MAX = 32'hFFFF_FFFF;
    localparam logic [RES_W-1:0]    RES_MAX  = 24'hFF_FFFF;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOLVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_ADD_RD, ST_ADD_CHK, ST_ADD_W1, ST_ADD_W2, ST_CLEAR,
        ST_BFS_INIT, ST_POP, ST_POP_CNT, ST_CNT_LOAD, ST_ARC_RD, ST_ARC_EVAL,
        ST_SEARCH_END, ST_PW_INIT, ST_PW_RD, ST_PW_ARC, ST_PW_EVAL, ST_PW_DONE,
        ST_AUG_INIT, ST_AUG_RD, ST_AUG_ARC, ST_AUG_SUB, ST_BK_RD, ST_BK_CHK,
        ST_AUG_NEXT, ST_TOTAL, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_ADD_RD, CMD_ADD_CHK, CMD_ADD_W1, CMD_ADD_W2,
        CMD_CLEAR, CMD_BFS_INIT, CMD_POP, CMD_POP_CNT, CMD_CNT_LOAD, CMD_ARC_RD,
        CMD_ARC_EVAL, CMD_PW_INIT, CMD_PW_RD, CMD_PW_ARC, CMD_PW_EVAL,
        CMD_AUG_INIT, CMD_AUG_RD, CMD_AUG_ARC, CMD_AUG_SUB, CMD_BK_RD,
        CMD_BK_CHK, CMD_AUG_NEXT, CMD_TOTAL, CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              range_err;
        logic              list_full;
        logic              head_eq_tail;
        logic              arc_done;
        logic              walk_done;
        logic              sink_reached;
        logic              amount_zero;
        logic              tgt_match;
        logic              out_busy;
    } dp_status_t;

endpackage

// ===== rtl/mfek_ctrl.sv =====
// Sequencer of the max flow core: edge load, clear and the search/augment loop.
// Depends on mfek_pkg; drives the datapath through cmd_t and reads dp_status_t.
module mfek_ctrl
    import mfek_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (status.mode)
                    MODE_ADD:   state_next = ST_ADD_RD;
                    MODE_SOLVE: state_next = ST_BFS_INIT;
                    MODE_CLEAR: state_next = ST_CLEAR;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_ADD_RD:  state_next = ST_ADD_CHK;
            ST_ADD_CHK: begin
                if (status.range_err || status.list_full) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_ADD_W1;
                end
            end
            ST_ADD_W1:   state_next = ST_ADD_W2;
            ST_ADD_W2:   state_next = ST_FINISH;
            ST_CLEAR:    state_next = ST_FINISH;
            ST_BFS_INIT: state_next = ST_POP;
            ST_POP: begin
                if (status.head_eq_tail) begin
                    state_next = ST_SEARCH_END;
                end else begin
                    state_next = ST_POP_CNT;
                end
            end
            ST_POP_CNT:  state_next = ST_CNT_LOAD;
            ST_CNT_LOAD: state_next = ST_ARC_RD;
            ST_ARC_RD: begin
                if (status.arc_done) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_ARC_EVAL;
                end
            end
            ST_ARC_EVAL: state_next = ST_ARC_RD;
            ST_SEARCH_END: begin
                if (status.sink_reached) begin
                    state_next = ST_PW_INIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_PW_INIT: state_next = ST_PW_RD;
            ST_PW_RD: begin
                if (status.walk_done) begin
                    state_next = ST_PW_DONE;
                end else begin
                    state_next = ST_PW_ARC;
                end
            end
            ST_PW_ARC:  state_next = ST_PW_EVAL;
            ST_PW_EVAL: state_next = ST_PW_RD;
            ST_PW_DONE: begin
                if (status.amount_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_AUG_INIT;
                end
            end
            ST_AUG_INIT: state_next = ST_AUG_RD;
            ST_AUG_RD: begin
                if (status.walk_done) begin
                    state_next = ST_TOTAL;
                end else begin
                    state_next = ST_AUG_ARC;
                end
            end
            ST_AUG_ARC: state_next = ST_AUG_SUB;
            ST_AUG_SUB: state_next = ST_BK_RD;
            ST_BK_RD: begin
                if (status.arc_done) begin
                    state_next = ST_AUG_NEXT;
                end else begin
                    state_next = ST_BK_CHK;
                end
            end
            ST_BK_CHK: begin
                if (status.tgt_match) begin
                    state_next = ST_AUG_NEXT;
                end else begin
                    state_next = ST_BK_RD;
                end
            end
            ST_AUG_NEXT: state_next = ST_AUG_RD;
            ST_TOTAL:    state_next = ST_BFS_INIT;
            ST_FINISH: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = CMD_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd = CMD_LOAD;
            end
            ST_ADD_RD:   cmd = CMD_ADD_RD;
            ST_ADD_CHK:  cmd = CMD_ADD_CHK;
            ST_ADD_W1:   cmd = CMD_ADD_W1;
            ST_ADD_W2:   cmd = CMD_ADD_W2;
            ST_CLEAR:    cmd = CMD_CLEAR;
            ST_BFS_INIT: cmd = CMD_BFS_INIT;
            ST_POP:      cmd = CMD_POP;
            ST_POP_CNT:  cmd = CMD_POP_CNT;
            ST_CNT_LOAD: cmd = CMD_CNT_LOAD;
            ST_ARC_RD:   cmd = CMD_ARC_RD;
            ST_ARC_EVAL: cmd = CMD_ARC_EVAL;
            ST_PW_INIT:  cmd = CMD_PW_INIT;
            ST_PW_RD:    cmd = CMD_PW_RD;
            ST_PW_ARC:   cmd = CMD_PW_ARC;
            ST_PW_EVAL:  cmd = CMD_PW_EVAL;
            ST_AUG_INIT: cmd = CMD_AUG_INIT;
            ST_AUG_RD:   cmd = CMD_AUG_RD;
            ST_AUG_ARC:  cmd = CMD_AUG_ARC;
            ST_AUG_SUB:  cmd = CMD_AUG_SUB;
            ST_BK_RD:    cmd = CMD_BK_RD;
            ST_BK_CHK:   cmd = CMD_BK_CHK;
            ST_AUG_NEXT: cmd = CMD_AUG_NEXT;
            ST_TOTAL:    cmd = CMD_TOTAL;
            ST_FINISH: begin
                if (!status.out_busy) cmd = CMD_EMIT;
            end
            default: cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/mfek_datapath.sv =====
// Datapath of the max flow core: arc, count, queue and parent memories,
// search and path registers, the vertex count register and the result word.
// Depends on mfek_pkg; steered by mfek_ctrl through cmd_t.
module mfek_datapath
    import mfek_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output dp_status_t             status,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   cfg_wr_en,
    input  logic [FIELD_W-1:0]     cfg_wr_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int SLOTS = MAX_VERTICES + 2;
    localparam int VW    = $clog2(SLOTS);
    localparam int XW    = ((VW > FIELD_W) ? VW : FIELD_W) + 1;
    localparam int QW    = $clog2(SLOTS + 1);
    localparam int CW    = $clog2(MAX_DEGREE + 1);
    localparam int SW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int ARCS  = SLOTS * MAX_DEGREE;
    localparam int AW    = $clog2(ARCS);
    localparam int PADW  = OUT_TDATA_W - FLOW_W - STATUS_W;

    function automatic logic [AW-1:0] arc_addr(input logic [VW-1:0] vtx,
                                               input logic [CW-1:0] slot);
        arc_addr = AW'(vtx) * AW'(MAX_DEGREE) + AW'(slot);
    endfunction

    logic [RES_W-1:0] arc_res_mem [ARCS];
    logic [VW-1:0]    arc_tgt_mem [ARCS];
    logic [CW-1:0]    cnt_mem     [SLOTS];
    logic [VW-1:0]    queue_mem   [SLOTS];
    logic [VW-1:0]    parent_mem  [SLOTS];
    logic [SW-1:0]    pslot_mem   [SLOTS];

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [FIELD_W-1:0]     vc_reg;
    logic [SLOTS-1:0]       cnt_vld_reg, cnt_vld_next;
    logic [SLOTS-1:0]       visited_reg, visited_next;

    logic [MODE_W-1:0]   mode_reg;
    logic [FIELD_W-1:0]  from_reg, to_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [FLOW_W-1:0]   flow_reg, amount_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [QW-1:0]       head_reg, tail_reg, steps_reg;
    logic [VW-1:0]       cur_reg, prev_reg;
    logic [CW-1:0]       i_reg, cnt_reg;
    logic [AW-1:0]       rd_addr_reg;

    logic [CW-1:0]    cnt_a_q, cnt_b_q;
    logic             cnt_a_vq, cnt_b_vq;
    logic [VW-1:0]    queue_q, parent_q, tgt_q;
    logic [SW-1:0]    pslot_q;
    logic [RES_W-1:0] res_q;

    logic [XW-1:0] nv_w;
    logic [VW-1:0] src, snk, u_v, v_v;
    logic [CW-1:0] cnt_a, cnt_b, slot_b;
    logic          take;
    logic [RES_W:0]  back_sum;
    logic [FLOW_W:0] total_sum;

    logic             cnt_re, cnt_we;
    logic [VW-1:0]    cnt_raddr_a, cnt_raddr_b, cnt_waddr;
    logic [CW-1:0]    cnt_wdata;
    logic             arc_re, tgt_we, res_we;
    logic [AW-1:0]    arc_raddr, arc_waddr;
    logic [VW-1:0]    arc_wtgt;
    logic [RES_W-1:0] arc_wres;
    logic             q_re, q_we, par_re, par_we;
    logic [VW-1:0]    q_raddr, q_waddr, q_wdata, par_raddr, par_waddr, par_wdata;
    logic [SW-1:0]    pslot_wdata;

    always_comb begin
        if (vc_reg == '0) begin
            nv_w = XW'(3);
        end else if (XW'(vc_reg) > XW'(MAX_VERTICES)) begin
            nv_w = XW'(MAX_VERTICES + 2);
        end else begin
            nv_w = XW'(vc_reg) + XW'(2);
        end
    end

    assign src    = VW'(nv_w - XW'(1));
    assign snk    = VW'(nv_w - XW'(2));
    assign u_v    = VW'(from_reg);
    assign v_v    = VW'(to_reg);
    assign cnt_a  = cnt_a_vq ? cnt_a_q : '0;
    assign cnt_b  = cnt_b_vq ? cnt_b_q : '0;
    assign slot_b = (u_v == v_v) ? cnt_a + CW'(1) : cnt_b;
    assign take   = (XW'(tgt_q) < nv_w) && !visited_reg[tgt_q] && (res_q != '0)
                    && (tail_reg < QW'(SLOTS));
    assign back_sum  = {1'b0, res_q} + {1'b0, amount_reg[RES_W-1:0]};
    assign total_sum = {1'b0, flow_reg} + {1'b0, amount_reg};

    always_comb begin
        status.mode         = mode_reg;
        status.range_err    = (XW'(from_reg) >= nv_w) || (XW'(to_reg) >= nv_w);
        if (u_v == v_v) begin
            status.list_full = (32'(cnt_a) + 2) > MAX_DEGREE;
        end else begin
            status.list_full = (32'(cnt_a) >= MAX_DEGREE) || (32'(cnt_b) >= MAX_DEGREE);
        end
        status.head_eq_tail = (head_reg == tail_reg);
        status.arc_done     = (i_reg >= cnt_reg);
        status.walk_done    = (cur_reg == src) || (XW'(steps_reg) >= nv_w);
        status.sink_reached = visited_reg[snk];
        status.amount_zero  = (amount_reg == '0);
        status.tgt_match    = (tgt_q == prev_reg);
        status.out_busy     = out_valid_reg && !m_tready;
    end

    always_comb begin
        cnt_re = 1'b0;  cnt_we = 1'b0;
        cnt_raddr_a = cur_reg;  cnt_raddr_b = v_v;
        cnt_waddr = u_v;  cnt_wdata = cnt_a + CW'(1);
        arc_re = 1'b0;  tgt_we = 1'b0;  res_we = 1'b0;
        arc_raddr = arc_addr(cur_reg, i_reg);
        arc_waddr = rd_addr_reg;  arc_wtgt = v_v;  arc_wres = RES_W'(cap_reg);
        q_re = 1'b0;  q_we = 1'b0;  q_raddr = VW'(head_reg);
        q_waddr = VW'(tail_reg);  q_wdata = tgt_q;
        par_re = 1'b0;  par_we = 1'b0;  par_raddr = cur_reg;
        par_waddr = tgt_q;  par_wdata = cur_reg;  pslot_wdata = SW'(i_reg);
        cnt_vld_next = cnt_vld_reg;
        visited_next = visited_reg;
        case (cmd)
            CMD_ADD_RD: begin
                cnt_re      = 1'b1;
                cnt_raddr_a = u_v;
            end
            CMD_ADD_W1: begin
                tgt_we    = 1'b1;
                res_we    = 1'b1;
                arc_waddr = arc_addr(u_v, cnt_a);
                cnt_we    = 1'b1;
                cnt_vld_next[u_v] = 1'b1;
            end
            CMD_ADD_W2: begin
                tgt_we    = 1'b1;
                res_we    = 1'b1;
                arc_waddr = arc_addr(v_v, slot_b);
                arc_wtgt  = u_v;
                arc_wres  = '0;
                cnt_we    = 1'b1;
                cnt_waddr = v_v;
                cnt_wdata = slot_b + CW'(1);
                cnt_vld_next[v_v] = 1'b1;
            end
            CMD_CLEAR: cnt_vld_next = '0;
            CMD_BFS_INIT: begin
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = src;
                visited_next = '0;
                visited_next[src] = 1'b1;
            end
            CMD_POP: q_re = 1'b1;
            CMD_POP_CNT: begin
                cnt_re      = 1'b1;
                cnt_raddr_a = queue_q;
            end
            CMD_ARC_RD: arc_re = 1'b1;
            CMD_ARC_EVAL: begin
                if (take) begin
                    q_we   = 1'b1;
                    par_we = 1'b1;
                    visited_next[tgt_q] = 1'b1;
                end
            end
            CMD_PW_RD: par_re = 1'b1;
            CMD_AUG_RD: begin
                par_re = 1'b1;
                cnt_re = 1'b1;
            end
            CMD_PW_ARC, CMD_AUG_ARC: begin
                arc_re    = 1'b1;
                arc_raddr = arc_addr(parent_q, CW'(pslot_q));
            end
            CMD_AUG_SUB: begin
                res_we   = 1'b1;
                arc_wres = res_q - amount_reg[RES_W-1:0];
            end
            CMD_BK_RD: arc_re = 1'b1;
            CMD_BK_CHK: begin
                if (tgt_q == prev_reg) begin
                    res_we   = 1'b1;
                    arc_wres = back_sum[RES_W] ? RES_MAX : back_sum[RES_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tgt_we) arc_tgt_mem[arc_waddr] <= arc_wtgt;
        if (res_we) arc_res_mem[arc_waddr] <= arc_wres;
        if (arc_re) begin
            tgt_q <= arc_tgt_mem[arc_raddr];
            res_q <= arc_res_mem[arc_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re) begin
            cnt_a_q  <= cnt_mem[cnt_raddr_a];
            cnt_b_q  <= cnt_mem[cnt_raddr_b];
            cnt_a_vq <= cnt_vld_reg[cnt_raddr_a];
            cnt_b_vq <= cnt_vld_reg[cnt_raddr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        if (q_re) queue_q <= queue_mem[q_raddr];
    end

    always_ff @(posedge aclk) begin
        if (par_we) begin
            parent_mem[par_waddr] <= par_wdata;
            pslot_mem[par_waddr]  <= pslot_wdata;
        end
        if (par_re) begin
            parent_q <= parent_mem[par_raddr];
            pslot_q  <= pslot_mem[par_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            vc_reg        <= VC_RESET;
            cnt_vld_reg   <= '0;
            visited_reg   <= '0;
        end else begin
            cnt_vld_reg <= cnt_vld_next;
            visited_reg <= visited_next;
            if (cfg_wr_en) vc_reg <= cfg_wr_data;
            if (cmd == CMD_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (arc_re) rd_addr_reg <= arc_raddr;
        case (cmd)
            CMD_LOAD: begin
                mode_reg   <= s_tdata[MODE_W-1:0];
                from_reg   <= s_tdata[MODE_W +: FIELD_W];
                to_reg     <= s_tdata[MODE_W+FIELD_W +: FIELD_W];
                cap_reg    <= s_tdata[MODE_W+2*FIELD_W +: CAP_W];
                flow_reg   <= '0;
                status_reg <= STATUS_OK;
            end
            CMD_ADD_CHK: begin
                if (status.range_err) begin
                    status_reg <= STATUS_RANGE;
                end else if (status.list_full) begin
                    status_reg <= STATUS_FULL;
                end
            end
            CMD_BFS_INIT: begin
                head_reg <= '0;
                tail_reg <= QW'(1);
            end
            CMD_POP: head_reg <= head_reg + QW'(1);
            CMD_POP_CNT: cur_reg <= queue_q;
            CMD_CNT_LOAD: begin
                cnt_reg <= cnt_a;
                i_reg   <= '0;
            end
            CMD_ARC_EVAL: begin
                if (take) tail_reg <= tail_reg + QW'(1);
                i_reg <= i_reg + CW'(1);
            end
            CMD_PW_INIT: begin
                cur_reg    <= snk;
                steps_reg  <= '0;
                amount_reg <= INT_MAX;
            end
            CMD_PW_ARC: prev_reg <= parent_q;
            CMD_PW_EVAL: begin
                if (FLOW_W'(res_q) < amount_reg) amount_reg <= FLOW_W'(res_q);
                cur_reg   <= prev_reg;
                steps_reg <= steps_reg + QW'(1);
            end
            CMD_AUG_INIT: begin
                cur_reg   <= snk;
                steps_reg <= '0;
            end
            CMD_AUG_ARC: begin
                prev_reg <= parent_q;
                cnt_reg  <= cnt_a;
            end
            CMD_AUG_SUB: i_reg <= '0;
            CMD_BK_CHK: i_reg <= i_reg + CW'(1);
            CMD_AUG_NEXT: begin
                cur_reg   <= prev_reg;
                steps_reg <= steps_reg + QW'(1);
            end
            CMD_TOTAL: flow_reg <= total_sum[FLOW_W] ? FLOW_MAX : total_sum[FLOW_W-1:0];
            CMD_EMIT: out_data_reg <= {{PADW{1'b0}}, status_reg, flow_reg};
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/max_flow_edmonds_karp_core.sv =====
// Channel  Dir  Ports                     Word
// s_       in   s_tvalid/s_tready/s_tdata  one command: add edge, solve or clear
// m_       out  m_tvalid/m_tready/m_tdata  one result per command
// cfg_     in   cfg_wr_en/cfg_wr_data      vertex count register
// One command is worked at a time. A solve runs searches, each followed by path walks when the
// sink is reached; a search takes vertices from the queue and scans their arcs, and a path found
// is walked for its bottleneck, then again to update each path arc and its reverse arc, if found.
// Reset is synchronous: it empties all arc lists and sets the vertex count to 64.
// A result waiting in the output register stalls the core only at its next result.
module max_flow_edmonds_karp_core
    import mfek_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mode[1:0], edge_from[8:2], edge_to[15:9], capacity[31:16]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // max_flow[31:0], status[33:32], zero[39:34]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [FIELD_W-1:0]     cfg_wr_data
);

    cmd_t       cmd;
    dp_status_t status;

    mfek_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mfek_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== rtl/mfek_checker.sv =====
// Port-level checks of the max flow core, bound to the top level.
// Depends on mfek_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfek_checker
    import mfek_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_wr_en,
    input logic [FIELD_W-1:0]     cfg_wr_data
);

    `MFEK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MFEK_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `MFEK_ASSERT_IMPL(a_status_code, aclk, aresetn, m_tvalid, m_tdata[33:32] != 2'd3)
    `MFEK_ASSERT_IMPL(a_flow_ok, aclk, aresetn, m_tvalid && (m_tdata[31:0] != '0), m_tdata[33:32] == STATUS_OK)
    `MFEK_ASSERT(a_pad_zero, aclk, aresetn, !m_tvalid || (m_tdata[39:34] == '0))

endmodule

bind max_flow_edmonds_karp_core mfek_checker u_mfek_checker (.*);

// ===== test/max_flow_edmonds_karp_core_tb.sv =====
// Self-checking testbench for the Edmonds-Karp max flow core.
// Depends on mfek_pkg and max_flow_edmonds_karp_core; predicts every result in place.
module max_flow_edmonds_karp_core_tb;
    import mfek_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV_MAX = 64;
    localparam int DEG = 16;
    localparam int SLOT_N = NV_MAX + 2;
    localparam int WATCH_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [FIELD_W-1:0] cfg_wr_data = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    max_flow_edmonds_karp_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    typedef struct packed {
        logic [FLOW_W-1:0]   flow;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Mirror of the graph held by the core.
    int unsigned graph_vc;
    int unsigned list_len[SLOT_N];
    int unsigned arc_dest[SLOT_N*DEG];
    int unsigned arc_res[SLOT_N*DEG];
    int unsigned bfs_parent[SLOT_N];
    int unsigned bfs_slot[SLOT_N];
    bit bfs_seen[SLOT_N];

    result_t expected_results[$];
    int errors = 0;
    int words_sent = 0;
    int words_seen = 0;
    int solves_sent = 0;
    int idle_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int unsigned live_vertices();
        int unsigned n;
        n = graph_vc;
        if (n < 1) n = 1;
        if (n > NV_MAX) n = NV_MAX;
        return n + 2;
    endfunction

    function automatic bit find_path(int unsigned nv, int unsigned src, int unsigned snk);
        int unsigned fifo[SLOT_N];
        int unsigned hd, tl, u, t, a;
        hd = 0;
        tl = 0;
        foreach (bfs_seen[k]) bfs_seen[k] = 1'b0;
        bfs_seen[src] = 1'b1;
        fifo[tl++] = src;
        while (hd < tl) begin
            u = fifo[hd++];
            for (int unsigned i = 0; i < list_len[u] && i < DEG; i++) begin
                a = u*DEG + i;
                t = arc_dest[a];
                if (t < nv && !bfs_seen[t] && arc_res[a] != 0 && tl < SLOT_N) begin
                    bfs_seen[t] = 1'b1;
                    bfs_parent[t] = u;
                    bfs_slot[t] = i;
                    fifo[tl++] = t;
                end
            end
        end
        return bfs_seen[snk];
    endfunction

    function automatic logic [FLOW_W-1:0] push_flow();
        int unsigned nv, src, snk, cur, steps, r, prev, b, back;
        longint unsigned amount, total, s;
        nv = live_vertices();
        src = nv - 1;
        snk = nv - 2;
        total = 0;
        while (find_path(nv, src, snk)) begin
            amount = INT_MAX;
            cur = snk;
            for (steps = 0; cur != src && steps < nv; steps++) begin
                r = arc_res[bfs_parent[cur]*DEG + bfs_slot[cur]];
                if (r < amount) amount = r;
                cur = bfs_parent[cur];
            end
            if (amount == 0) break;
            cur = snk;
            for (steps = 0; cur != src && steps < nv; steps++) begin
                prev = bfs_parent[cur];
                arc_res[prev*DEG + bfs_slot[cur]] -= amount;
                back = DEG;
                for (int unsigned i = 0; i < list_len[cur] && i < DEG; i++)
                    if (back == DEG && arc_dest[cur*DEG + i] == prev) back = i;
                if (back < DEG) begin
                    b = cur*DEG + back;
                    s = arc_res[b] + amount;
                    arc_res[b] = (s > RES_MAX) ? RES_MAX : s;
                end
                cur = prev;
            end
            total = (total + amount > FLOW_MAX) ? FLOW_MAX : total + amount;
        end
        return total[FLOW_W-1:0];
    endfunction

    function automatic logic [STATUS_W-1:0] load_edge(int unsigned u, int unsigned v,
                                                      int unsigned cap);
        int unsigned nv;
        nv = live_vertices();
        if (u >= nv || v >= nv) return STATUS_RANGE;
        if (u == v) begin
            if (list_len[u] + 2 > DEG) return STATUS_FULL;
        end else if (list_len[u] >= DEG || list_len[v] >= DEG) begin
            return STATUS_FULL;
        end
        arc_dest[u*DEG + list_len[u]] = v;
        arc_res[u*DEG + list_len[u]] = cap;
        list_len[u]++;
        arc_dest[v*DEG + list_len[v]] = u;
        arc_res[v*DEG + list_len[v]] = 0;
        list_len[v]++;
        return STATUS_OK;
    endfunction

    function automatic result_t predict_word(logic [IN_TDATA_W-1:0] w);
        result_t r;
        r = '0;
        case (w[1:0])
            MODE_ADD: r.status = load_edge(w[8:2], w[15:9], w[31:16]);
            MODE_SOLVE: r.flow = push_flow();
            MODE_CLEAR: foreach (list_len[k]) list_len[k] = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(logic [MODE_W-1:0] mode, int unsigned u, int unsigned v,
                             int unsigned cap);
        logic [IN_TDATA_W-1:0] w;
        w = {cap[15:0], v[6:0], u[6:0], mode};
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_word(w));
        words_sent++;
        if (mode == MODE_SOLVE) solves_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_vertex_count(int unsigned n);
        drain();
        cfg_wr_data <= n[6:0];
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        graph_vc = n & 32'h7F;
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{flow: m_tdata[31:0], status: m_tdata[33:32]};
            words_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.flow !== want.flow) begin
                    $error("max_flow expected %0d actual %0d", want.flow, got.flow);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCH_LIMIT) begin
            $display("watchdog expired");
            $display("max_flow_edmonds_karp_core: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        // Small network: source 5, sink 4 at vertex count 4.
        write_vertex_count(4);
        send_word(MODE_ADD, 5, 0, 10);
        send_word(MODE_ADD, 5, 1, 65535);
        send_word(MODE_ADD, 0, 1, 2);
        send_word(MODE_ADD, 0, 4, 4);
        send_word(MODE_ADD, 1, 4, 9);
        send_word(MODE_ADD, 1, 1, 3);
        send_word(MODE_ADD, 2, 2, 0);
        send_word(MODE_ADD, 6, 0, 1);
        send_word(MODE_ADD, 0, 127, 1);
        send_word(MODE_SOLVE, 0, 0, 0);
        send_word(MODE_SOLVE, 0, 0, 0);
        send_word(MODE_ADD, 0, 4, 7);
        send_word(MODE_SOLVE, 0, 0, 0);
        send_word(2'd3, 127, 127, 65535);
        // Add 14 arcs to the list of vertex 3, which stays short of full.
        for (int i = 0; i < 9; i++) send_word(MODE_ADD, 3, i % 2 ? 2 : 3, i);
        send_word(MODE_CLEAR, 0, 0, 0);
        send_word(MODE_SOLVE, 0, 0, 0);
    endtask

    task automatic test_vertex_count_extremes();
        write_vertex_count(0);
        send_word(MODE_ADD, 2, 0, 100);
        send_word(MODE_ADD, 0, 1, 60);
        send_word(MODE_ADD, 2, 1, 5);
        send_word(MODE_ADD, 3, 1, 5);
        send_word(MODE_SOLVE, 0, 0, 0);
        send_word(MODE_CLEAR, 0, 0, 0);
        write_vertex_count(127);
        send_word(MODE_ADD, 65, 10, 40000);
        send_word(MODE_ADD, 10, 64, 30000);
        send_word(MODE_ADD, 65, 64, 65535);
        write_vertex_count(20);
        send_word(MODE_SOLVE, 0, 0, 0);
        write_vertex_count(64);
        send_word(MODE_SOLVE, 0, 0, 0);
        send_word(MODE_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random_graphs(int phase_idle, int phase_stall, int graphs);
        int unsigned nv, u, v;
        send_idle_pct = phase_idle;
        recv_stall_pct = phase_stall;
        for (int g = 0; g < graphs; g++) begin
            write_vertex_count($urandom_range(8, 1));
            nv = live_vertices();
            for (int e = $urandom_range(8, 3); e > 0; e--) begin
                u = ($urandom_range(3) == 0) ? nv - 1 : $urandom_range(nv - 1);
                v = ($urandom_range(3) == 0) ? nv - 2 : $urandom_range(nv - 1);
                if ($urandom_range(15) == 0) u = $urandom_range(127);
                send_word(MODE_ADD, u, v, $urandom_range(3) == 0 ?
                          $urandom_range(65535) : $urandom_range(20));
            end
            send_word(MODE_SOLVE, $urandom_range(127), $urandom_range(127),
                      $urandom_range(65535));
            if ($urandom_range(3) == 0) send_word(2'd3, $urandom_range(127),
                                                  $urandom_range(127), $urandom_range(65535));
            if ($urandom_range(1)) send_word(MODE_SOLVE, 0, 0, 0);
            send_word(MODE_CLEAR, 0, 0, 0);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        graph_vc = VC_RESET;
        foreach (list_len[k]) list_len[k] = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_vertex_count_extremes();
        test_random_graphs(0, 0, 3);
        test_random_graphs(49, 0, 3);
        test_random_graphs(0, 49, 3);
        test_random_graphs(8, 8, 3);
        drain();
        $display("Sent %0d command words including %0d solves over vertex counts 0 to 127,",
                 words_sent, solves_sent);
        $display("checked %0d result words under sender and receiver stalls.", words_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("max_flow_edmonds_karp_core: match");
        else
            $display("max_flow_edmonds_karp_core: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mfek_pkg.sv
rtl/mfek_ctrl.sv
rtl/mfek_datapath.sv
rtl/max_flow_edmonds_karp_core.sv
rtl/mfek_checker.sv
test/max_flow_edmonds_karp_core_tb.sv
